/* src/insertion_sorter_defines.svh */
// Assertion macros used by the sorter RTL.
`ifndef INSERTION_SORTER_DEFINES_SVH
`define INSERTION_SORTER_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define ISORT_ASSERT_HOLDS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define ISORT_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define ISORT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/isort_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package isort_pkg;

   localparam int CAPACITY = 8;
   localparam int VALUE_W  = 32;
   localparam int MOVE_W   = 5;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int SUM_W    = (MOVE_W > COUNT_W) ? MOVE_W + 1 : COUNT_W + 1;
   localparam int MOVE_MAX = (2 ** MOVE_W) - 1;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] sorted_value;
      logic                      final_res;
      logic [MOVE_W-1:0]         move_count;
      logic                      overflow;
   } rsp_type;

   // What the row of cells does in a cycle.
   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      STATE_IDLE  = 2'b01,
      STATE_DRAIN = 2'b10
   } state_type;

endpackage

`default_nettype wire

/* src/isort_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module isort_cell (
   input  wire logic                               clock,
   input  wire isort_pkg::cell_ctrl_type           ctrl,
   input  wire logic signed [isort_pkg::VALUE_W-1:0] new_value,
   input  wire logic signed [isort_pkg::VALUE_W-1:0] left_value,
   input  wire logic                               left_gt,
   input  wire logic signed [isort_pkg::VALUE_W-1:0] right_value,
   input  wire logic                               occupied,
   input  wire logic                               at_end,
   output logic signed [isort_pkg::VALUE_W-1:0]      entry,
   output logic                                    gt
);
   import isort_pkg::*;

   logic signed [VALUE_W-1:0] entry_ff;
   logic signed [VALUE_W-1:0] entry_in;

   // Only strictly greater entries move, so equal values keep arrival order.
   assign gt = occupied && (entry_ff > new_value);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.shift) begin
         entry_in = right_value;
      end else if (ctrl.insert && (gt || at_end)) begin
         entry_in = left_gt ? left_value : new_value;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

/* src/insertion_sorter.sv */
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one value per clock cycle while busy is low; every cell compares in parallel.
// Storage: a value not marked last is stored at its accepting edge and gives no result.
// A last value starts the drain, which keeps busy high until the last held value leaves cell zero; the results
// come one per cycle, each registered out of cell zero during a drain cycle. The receiver cannot stall.
// Reset (synchronous, active high) clears the count, the move counter and the overflow flag;
// the stored values are left as they are and are never read before being written.

`include "insertion_sorter_defines.svh"

module insertion_sorter (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire isort_pkg::req_type req_data,
   output logic                    rsp_strobe,
   output isort_pkg::rsp_type      rsp_data
);
   import isort_pkg::*;

   // Control state. The fill count doubles as the countdown while the row drains.
   state_type             state_ff, state_in;
   logic [COUNT_W-1:0]    held_count_ff, held_count_in;
   logic [MOVE_W-1:0]     moves_ff, moves_in;
   logic                  dropped_ff, dropped_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  full;
   cell_ctrl_type         ctrl;
   logic signed [VALUE_W-1:0] entry [CAPACITY];
   logic [CAPACITY-1:0]   gt;
   logic [COUNT_W-1:0]    insert_pos;
   logic [COUNT_W-1:0]    pos_or;
   logic [COUNT_W-1:0]    item_moves;
   logic [SUM_W-1:0]      move_sum;
   logic [MOVE_W-1:0]     moves_sat;
   logic                  final_transfer;

   assign busy   = (state_ff == STATE_DRAIN);
   assign accept = start && !busy;
   assign full   = (held_count_ff == COUNT_W'(CAPACITY));

   // The row inserts on an accepted value when there is room, and shifts towards
   // cell zero while draining, one held value leaving per cycle.
   assign ctrl.insert = accept && !full;
   assign ctrl.shift  = busy;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [VALUE_W-1:0] left_value;
      logic signed [VALUE_W-1:0] right_value;
      logic                      left_gt;

      if (g == 0) begin : g_first
         assign left_value = req_data.value;
         assign left_gt    = 1'b0;
      end else begin : g_inner
         assign left_value = entry[g-1];
         assign left_gt    = gt[g-1];
      end

      if (g == CAPACITY - 1) begin : g_tail
         assign right_value = entry[g];
      end else begin : g_body
         assign right_value = entry[g+1];
      end

      isort_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .new_value   (req_data.value),
         .left_value  (left_value),
         .left_gt     (left_gt),
         .right_value (right_value),
         .occupied    (held_count_ff > COUNT_W'(g)),
         .at_end      (held_count_ff == COUNT_W'(g)),
         .entry       (entry[g]),
         .gt          (gt[g])
      );
   end

   // The greater entries form a run at the top of the store, so the new value lands
   // at the first of them and every entry of the run is one move.
   always_comb begin
      pos_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (gt[i] && ((i == 0) || !gt[(i == 0) ? 0 : i - 1])) begin
            pos_or = pos_or | COUNT_W'(i);
         end
      end
   end

   assign insert_pos = (|gt) ? pos_or : held_count_ff;
   assign item_moves = held_count_ff - insert_pos;
   assign move_sum   = SUM_W'(moves_ff) + SUM_W'(item_moves);
   assign moves_sat  = (move_sum > SUM_W'(MOVE_MAX)) ? MOVE_W'(MOVE_MAX) : move_sum[MOVE_W-1:0];

   assign final_transfer = busy && (held_count_ff == COUNT_W'(1));

   always_comb begin
      state_in      = state_ff;
      held_count_in = held_count_ff;
      moves_in      = moves_ff;
      dropped_in    = dropped_ff;
      rsp_strobe_in = 1'b0;

      rsp_data_in.sorted_value = entry[0];
      rsp_data_in.final_res    = final_transfer;
      rsp_data_in.move_count   = final_transfer ? moves_ff : '0;
      rsp_data_in.overflow     = final_transfer && dropped_ff;

      case (state_ff)
         STATE_IDLE: begin
            if (accept) begin
               if (full) begin
                  // No room: the value is lost and the run is marked.
                  dropped_in = 1'b1;
               end else begin
                  held_count_in = held_count_ff + COUNT_W'(1);
                  moves_in      = moves_sat;
               end
               if (req_data.last) begin
                  state_in = STATE_DRAIN;
               end
            end
         end
         STATE_DRAIN: begin
            // Cell zero always holds the smallest value still waiting.
            rsp_strobe_in = 1'b1;
            held_count_in = held_count_ff - COUNT_W'(1);
            if (final_transfer) begin
               state_in   = STATE_IDLE;
               moves_in   = '0;
               dropped_in = 1'b0;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= STATE_IDLE;
         held_count_ff <= '0;
         moves_ff      <= '0;
         dropped_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_count_ff <= held_count_in;
         moves_ff      <= moves_in;
         dropped_ff    <= dropped_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // The count never passes the number of cells.
   `ISORT_ASSERT_HOLDS(a_count_bound, held_count_ff <= COUNT_W'(CAPACITY), "count above capacity")
   // The final transfer of a run leaves the block idle and empty.
   `ISORT_ASSERT_IMPLIES(a_final_idle, rsp_strobe_ff && rsp_data_ff.final_res, state_ff == STATE_IDLE && held_count_ff == '0, "final transfer without idle")
   // Transfers other than the final one carry neither count nor overflow.
   `ISORT_ASSERT_IMPLIES(a_nonfinal_clear, rsp_strobe_ff && !rsp_data_ff.final_res, rsp_data_ff.move_count == '0 && !rsp_data_ff.overflow, "status on non-final transfer")
   // A run of transfers has no gap before its final one.
   `ISORT_ASSERT_NEXT(a_run_contiguous, rsp_strobe_ff && !rsp_data_ff.final_res, rsp_strobe_ff, "gap in result run")
   // Accepting a last value starts the drain.
   `ISORT_ASSERT_NEXT(a_last_drains, accept && req_data.last, state_ff == STATE_DRAIN, "last value did not start drain")

endmodule

`default_nettype wire
